@@ design/stpool_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpool_pkg
// shared types, codes and helpers of the sorted top-k solution pool
// ----------------------------------------------------------------------------
package stpool_pkg;

  localparam int DEF_MAX_SOLS  = 16;
  localparam int DEF_MAX_EDGES = 1024;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_EDGE_COUNT    = 2'd0,
    CFG_POOL_CAPACITY = 2'd1,
    CFG_TOLERANCE     = 2'd2
  } cfg_idx_e;

  // one stored solution as seen by a rank cell
  typedef struct packed {
    logic signed [31:0] objective;
    logic [31:0]        run_index;
  } rec_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [31:0] stored_edge;
    logic signed [31:0] stored_objective;
    logic [31:0]        assigned_index;
    logic [3:0]         rank;
    logic               found;
    logic               contained;
    logic               added;
  } res_t;

  // a greater than b by more than tol
  function automatic logic obj_gt(logic signed [31:0] a, logic signed [31:0] b,
                                  logic [30:0] tol);
    logic signed [33:0] diff;
    logic signed [33:0] lim;
    diff = 34'(a) - 34'(b);
    lim  = signed'({3'b000, tol});
    return diff > lim;
  endfunction

endpackage

@@ design/stpool_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpool_bank
// one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module stpool_bank #(
  parameter int DEPTH = stpool_pkg::DEF_MAX_EDGES,
  parameter int AW    = 10
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/stpool_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpool_cell
// one rank position: slot number, objective and running index
// ----------------------------------------------------------------------------
module stpool_cell #(
  parameter int IDX = 0,
  parameter int SW  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stpool_pkg::cell_ctl_t ctl_i,
  input  stpool_pkg::rec_t      new_rec_i,
  input  logic [SW-1:0]         new_slot_i,
  input  stpool_pkg::rec_t      up_rec_i,
  input  logic [SW-1:0]         up_slot_i,
  output stpool_pkg::rec_t      rec_o,
  output logic [SW-1:0]         slot_o
);

  stpool_pkg::rec_t rec_q;
  logic [SW-1:0]    slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SW'(IDX);
    end else if (ctl_i.load_en) begin
      slot_q <= new_slot_i;
    end else if (ctl_i.shift_en) begin
      slot_q <= up_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_en) begin
      rec_q <= new_rec_i;
    end else if (ctl_i.shift_en) begin
      rec_q <= up_rec_i;
    end
  end

  assign rec_o  = rec_q;
  assign slot_o = slot_q;

endmodule

@@ design/sorted_topk_solution_pool_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_topk_solution_pool_top
// bounded pool of solution vectors sorted by ascending objective
// ----------------------------------------------------------------------------
// A non-closing add or contains word is written to the candidate buffer. A closing
// word runs a compare pass over edge_count positions (all slot banks read in
// parallel against the candidate buffer), then for a stored add an insert walk
// up the rank cells (one rank per cycle, up to MAX_SOLS) and a copy pass into
// the slot bank. Lookup scans the ranks one per cycle, read adds a registered
// bank access. No clearing pass.
module sorted_topk_solution_pool_top #(
  parameter int MAX_SOLS  = stpool_pkg::DEF_MAX_SOLS,
  parameter int MAX_EDGES = stpool_pkg::DEF_MAX_EDGES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // edge_value[31:0] edge_pos[41:32] objective[73:42] query_index[105:74]
  input  logic [stpool_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                         s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // added[0] contained[1] found[2] rank[6:3] assigned_index[38:7]
  // stored_objective[70:39] stored_edge[102:71]
  output logic [stpool_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [30:0]                        cfg_data_i
);

  localparam int SW = (MAX_SOLS > 1) ? $clog2(MAX_SOLS) : 1;
  localparam int FW = $clog2(MAX_SOLS + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DECIDE,
    ST_SHIFT,
    ST_COPY,
    ST_LOOK,
    ST_RDWAIT
  } state_e;

  state_e state_q;

  logic [10:0] edge_count_q;
  logic [4:0]  pool_capacity_q;
  logic [30:0] tolerance_q;

  logic [EW-1:0] eff_e;
  logic [FW-1:0] eff_cap;

  always_comb begin
    if (edge_count_q == 11'd0) begin
      eff_e = EW'(1);
    end else if (32'(edge_count_q) > MAX_EDGES) begin
      eff_e = EW'(MAX_EDGES);
    end else begin
      eff_e = EW'(edge_count_q);
    end
    if (pool_capacity_q == 5'd0) begin
      eff_cap = FW'(1);
    end else if (32'(pool_capacity_q) > MAX_SOLS) begin
      eff_cap = FW'(MAX_SOLS);
    end else begin
      eff_cap = FW'(pool_capacity_q);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q    <= 11'd1024;
      pool_capacity_q <= 5'd16;
      tolerance_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stpool_pkg::CFG_EDGE_COUNT:    edge_count_q    <= cfg_data_i[10:0];
        stpool_pkg::CFG_POOL_CAPACITY: pool_capacity_q <= cfg_data_i[4:0];
        stpool_pkg::CFG_TOLERANCE:     tolerance_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic signed [31:0] in_edge;
  logic [9:0]         in_pos;
  logic signed [31:0] in_obj;
  logic [31:0]        in_qidx;
  logic [1:0]         in_op;
  logic               in_acc;

  assign in_edge = s_axis_tdata[31:0];
  assign in_pos  = s_axis_tdata[41:32];
  assign in_obj  = s_axis_tdata[73:42];
  assign in_qidx = s_axis_tdata[105:74];
  assign in_op   = s_axis_tuser;

  logic               out_valid_q;
  stpool_pkg::res_t   res_q;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.stored_edge, res_q.stored_objective,
                          res_q.assigned_index, res_q.rank, res_q.found,
                          res_q.contained, res_q.added};

  // working registers
  logic [EW-1:0]      cnt_q;
  logic [EW-1:0]      ccnt_q;
  logic [EW-1:0]      j_q;
  logic [EW-1:0]      aj_q;
  logic               v1_q;
  logic [1:0]         op_q;
  logic signed [31:0] obj_q;
  logic [31:0]        qidx_q;
  logic [9:0]         epos_q;
  logic [FW-1:0]      fill_q;
  logic [31:0]        next_idx_q;
  logic [31:0]        run_q;
  logic [SW-1:0]      new_slot_q;
  logic [SW-1:0]      hit_slot_q;
  logic [FW-1:0]      i_q;
  logic [FW-1:0]      r_q;
  logic [MAX_SOLS-1:0] smis_q;

  // memories
  logic signed [31:0] cand_rd;
  logic signed [31:0] bank_rd [MAX_SOLS];
  logic [AW-1:0]      rd_addr;
  logic               cand_we;
  logic signed [31:0] cval;

  assign cand_we = in_acc && (in_op == stpool_pkg::OP_ADD || in_op == stpool_pkg::OP_CONTAINS)
                   && (cnt_q < eff_e);
  assign rd_addr = (state_q == ST_LOOK) ? AW'(epos_q) : j_q[AW-1:0];
  assign cval    = (aj_q < ccnt_q) ? cand_rd : 32'sd0;

  stpool_bank #(.DEPTH(MAX_EDGES), .AW(AW)) u_cand (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_edge),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (cand_rd)
  );

  // rank cells
  stpool_pkg::rec_t      cell_rec  [MAX_SOLS];
  logic [SW-1:0]         cell_slot [MAX_SOLS];
  stpool_pkg::cell_ctl_t cell_ctl  [MAX_SOLS];
  stpool_pkg::rec_t      new_rec;
  logic [SW-1:0]         sidx;
  stpool_pkg::rec_t      sel_rec;
  logic [SW-1:0]         sel_slot;
  logic                  shift_go;
  logic                  full;
  logic                  any_match;

  assign new_rec.objective = obj_q;
  assign new_rec.run_index = run_q;
  assign full     = (fill_q >= eff_cap);
  assign sel_rec  = cell_rec[sidx];
  assign sel_slot = cell_slot[sidx];
  assign shift_go = (i_q != '0) &&
                    !stpool_pkg::obj_gt(obj_q, sel_rec.objective, tolerance_q);

  always_comb begin
    unique case (state_q)
      ST_DECIDE: sidx = full ? SW'(fill_q - FW'(1)) : SW'(fill_q);
      ST_SHIFT:  sidx = SW'(i_q - FW'(1));
      default:   sidx = SW'(r_q);
    endcase
  end

  always_comb begin
    any_match = 1'b0;
    for (int k = 0; k < MAX_SOLS; k++) begin
      if ((FW'(k) < fill_q) && !smis_q[cell_slot[k]]) begin
        any_match = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < MAX_SOLS; k++) begin : g_cell
    assign cell_ctl[k].shift_en = (state_q == ST_SHIFT) && shift_go && (i_q == FW'(k));
    assign cell_ctl[k].load_en  = (state_q == ST_SHIFT) && !shift_go && (i_q == FW'(k));

    stpool_cell #(.IDX(k), .SW(SW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl[k]),
      .new_rec_i  (new_rec),
      .new_slot_i (new_slot_q),
      .up_rec_i   (cell_rec[(k == 0) ? 0 : k - 1]),
      .up_slot_i  (cell_slot[(k == 0) ? 0 : k - 1]),
      .rec_o      (cell_rec[k]),
      .slot_o     (cell_slot[k])
    );

    stpool_bank #(.DEPTH(MAX_EDGES), .AW(AW)) u_bank (
      .clk_i   (clk_i),
      .we_i    ((state_q == ST_COPY) && v1_q && (new_slot_q == SW'(k))),
      .waddr_i (aj_q[AW-1:0]),
      .wdata_i (cval),
      .raddr_i (rd_addr),
      .rdata_o (bank_rd[k])
    );
  end

  logic pass_end;
  assign pass_end = v1_q && (aj_q == eff_e - EW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      cnt_q       <= '0;
      ccnt_q      <= '0;
      j_q         <= '0;
      aj_q        <= '0;
      v1_q        <= 1'b0;
      op_q        <= '0;
      obj_q       <= '0;
      qidx_q      <= '0;
      epos_q      <= '0;
      fill_q      <= '0;
      next_idx_q  <= '0;
      run_q       <= '0;
      new_slot_q  <= '0;
      hit_slot_q  <= '0;
      i_q         <= '0;
      r_q         <= '0;
      smis_q      <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q   <= in_op;
            obj_q  <= in_obj;
            qidx_q <= in_qidx;
            epos_q <= in_pos;
            if (in_op == stpool_pkg::OP_ADD || in_op == stpool_pkg::OP_CONTAINS) begin
              if (s_axis_tlast) begin
                ccnt_q  <= (cnt_q < EW'(MAX_EDGES)) ? cnt_q + EW'(1) : cnt_q;
                cnt_q   <= '0;
                j_q     <= '0;
                v1_q    <= 1'b0;
                smis_q  <= '0;
                state_q <= ST_CMP;
              end else if (cnt_q < EW'(MAX_EDGES)) begin
                cnt_q <= cnt_q + EW'(1);
              end
            end else begin
              r_q     <= '0;
              state_q <= ST_LOOK;
            end
          end
        end
        ST_CMP: begin
          if (j_q < eff_e) begin
            v1_q <= 1'b1;
            aj_q <= j_q;
            j_q  <= j_q + EW'(1);
          end else begin
            v1_q <= 1'b0;
          end
          if (v1_q) begin
            for (int s = 0; s < MAX_SOLS; s++) begin
              if (bank_rd[s] != cval) begin
                smis_q[s] <= 1'b1;
              end
            end
          end
          if (pass_end) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (any_match) begin
            res_q       <= '{contained: 1'b1, default: '0};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (op_q == stpool_pkg::OP_CONTAINS ||
                       (full && stpool_pkg::obj_gt(obj_q, sel_rec.objective, tolerance_q)))
          begin
            res_q       <= '0;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            new_slot_q <= sel_slot;
            run_q      <= next_idx_q;
            next_idx_q <= next_idx_q + 32'd1;
            if (full) begin
              i_q <= fill_q - FW'(1);
            end else begin
              i_q    <= fill_q;
              fill_q <= fill_q + FW'(1);
            end
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (shift_go) begin
            i_q <= i_q - FW'(1);
          end else begin
            j_q     <= '0;
            v1_q    <= 1'b0;
            state_q <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (j_q < eff_e) begin
            v1_q <= 1'b1;
            aj_q <= j_q;
            j_q  <= j_q + EW'(1);
          end else begin
            v1_q <= 1'b0;
          end
          if (pass_end) begin
            res_q       <= '{added: 1'b1, rank: 4'(i_q), assigned_index: run_q,
                             default: '0};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_LOOK: begin
          if (r_q >= fill_q) begin
            res_q       <= '0;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (sel_rec.run_index == qidx_q) begin
            res_q      <= '{found: 1'b1, rank: 4'(r_q),
                            assigned_index: sel_rec.run_index,
                            stored_objective: sel_rec.objective, default: '0};
            hit_slot_q <= sel_slot;
            if (op_q == stpool_pkg::OP_READ && 32'(epos_q) < 32'(eff_e) &&
                32'(epos_q) < MAX_EDGES) begin
              state_q <= ST_RDWAIT;
            end else begin
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end else begin
            r_q <= r_q + FW'(1);
          end
        end
        ST_RDWAIT: begin
          res_q.stored_edge <= bank_rd[hit_slot_q];
          out_valid_q       <= 1'b1;
          state_q           <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/stpool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpool_checker
// port-level checks of the solution pool, bound to the top level
// ----------------------------------------------------------------------------
module stpool_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [stpool_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // at most one outcome flag per word
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
    else $error("more than one outcome flag");

  // a word with no add and no hit carries nothing else
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0] && !m_axis_tdata[2]) |->
      (m_axis_tdata[102:3] == '0))
    else $error("stale fields in empty word");

  // an add reports no objective or edge
  a_add_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[102:39] == '0))
    else $error("add word carries lookup fields");

  // a stalled word stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word dropped under stall");

  // no input word taken while a result word is stuck
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while output stalled");

endmodule

bind sorted_topk_solution_pool_top stpool_checker u_stpool_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
